FILE: hw/rtl/schroeder_reverb_channel_defines.svh
// ----------------------------------------------------------------------------
// Reverb channel assertion macros
// Shared concurrent assertion forms for the reverb channel modules.
// ----------------------------------------------------------------------------
`ifndef SCHROEDER_REVERB_CHANNEL_DEFINES_SVH
`define SCHROEDER_REVERB_CHANNEL_DEFINES_SVH

// same-cycle implication
`define SRV_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define SRV_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: hw/rtl/srv_pkg.sv
// ----------------------------------------------------------------------------
// Reverb channel package
// Configuration, command and status types shared by the reverb modules.
// ----------------------------------------------------------------------------
package srv_pkg;

   localparam int NCOMB    = 4;
   localparam int NAP      = 2;
   localparam int ADDR_W   = 6;
   localparam int DATA_W   = 64;

   localparam logic [2:0] REG_PD_LENGTH       = 3'd0;
   localparam logic [2:0] REG_COMB_LENGTHS    = 3'd1;
   localparam logic [2:0] REG_ALLPASS_LENGTHS = 3'd2;
   localparam logic [2:0] REG_COMB_FEEDBACKS  = 3'd3;
   localparam logic [2:0] REG_DAMPING         = 3'd4;
   localparam logic [2:0] REG_WET_GAIN        = 3'd5;
   localparam logic [2:0] REG_DRY_GAIN        = 3'd6;

   typedef struct packed {
      logic [14:0] pd_length;
      logic [47:0] comb_lengths;
      logic [17:0] allpass_lengths;
      logic [59:0] comb_feedbacks;
      logic [14:0] damping;
      logic [15:0] wet_gain;
      logic [15:0] dry_gain;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_PD_READ,
      OP_PD_WRITE,
      OP_CB_READ,
      OP_CB_MUL_Y,
      OP_CB_MUL_LP,
      OP_CB_LP,
      OP_CB_MUL_FB,
      OP_CB_WRITE,
      OP_AP_READ,
      OP_AP_MUL,
      OP_AP_WRITE,
      OP_MIX_DRY,
      OP_MIX_WET,
      OP_OUT
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic clear_busy;
      logic out_full;
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PD,
      ST_CRD,
      ST_CMY,
      ST_CMLP,
      ST_CLP,
      ST_CMFB,
      ST_CWR,
      ST_ARD,
      ST_AMUL,
      ST_AWR,
      ST_DRY,
      ST_WET,
      ST_OUT
   } state_type;

endpackage

FILE: hw/rtl/srv_if.sv
// ----------------------------------------------------------------------------
// Reverb channel stream interfaces
// Valid/ready channels for input samples and mixed output samples.
// ----------------------------------------------------------------------------
interface srv_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface srv_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: hw/rtl/srv_csr.sv
// ----------------------------------------------------------------------------
// Reverb channel register block
// APB-style register file holding delay lengths, gains and damping.
// ----------------------------------------------------------------------------
module srv_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [srv_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [srv_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [srv_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready,
   output srv_pkg::cfg_type            cfg
);
   import srv_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_idx;
   logic       wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[ADDR_W-1:3];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PD_LENGTH:       cfg_in.pd_length       = csr_pwdata[14:0];
            REG_COMB_LENGTHS:    cfg_in.comb_lengths    = csr_pwdata[47:0];
            REG_ALLPASS_LENGTHS: cfg_in.allpass_lengths = csr_pwdata[17:0];
            REG_COMB_FEEDBACKS:  cfg_in.comb_feedbacks  = csr_pwdata[59:0];
            REG_DAMPING:         cfg_in.damping         = csr_pwdata[14:0];
            REG_WET_GAIN:        cfg_in.wet_gain        = csr_pwdata[15:0];
            REG_DRY_GAIN:        cfg_in.dry_gain        = csr_pwdata[15:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PD_LENGTH:       csr_prdata = DATA_W'(cfg_ff.pd_length);
         REG_COMB_LENGTHS:    csr_prdata = DATA_W'(cfg_ff.comb_lengths);
         REG_ALLPASS_LENGTHS: csr_prdata = DATA_W'(cfg_ff.allpass_lengths);
         REG_COMB_FEEDBACKS:  csr_prdata = DATA_W'(cfg_ff.comb_feedbacks);
         REG_DAMPING:         csr_prdata = DATA_W'(cfg_ff.damping);
         REG_WET_GAIN:        csr_prdata = DATA_W'(cfg_ff.wet_gain);
         REG_DRY_GAIN:        csr_prdata = DATA_W'(cfg_ff.dry_gain);
         default:             csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pd_length       <= 15'd1;
         cfg_ff.comb_lengths    <= 48'd144206570935698;
         cfg_ff.allpass_lengths <= 18'd42224;
         cfg_ff.comb_feedbacks  <= '0;
         cfg_ff.damping         <= '0;
         cfg_ff.wet_gain        <= '0;
         cfg_ff.dry_gain        <= 16'd16384;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/srv_ctrl.sv
// ----------------------------------------------------------------------------
// Reverb channel sequencer
// Steps one sample through predelay, combs, allpasses and the output mix.
// ----------------------------------------------------------------------------
`include "schroeder_reverb_channel_defines.svh"

module srv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  srv_pkg::status_type status,
   output srv_pkg::cmd_type    cmd
);
   import srv_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      cmd.op    = OP_NOP;
      cmd.idx   = idx_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = !status.clear_busy;
            if (req_valid && !status.clear_busy) begin
               cmd.op   = OP_PD_READ;
               state_in = ST_PD;
            end
         end
         ST_PD: begin
            cmd.op   = OP_PD_WRITE;
            idx_in   = '0;
            state_in = ST_CRD;
         end
         ST_CRD: begin
            cmd.op   = OP_CB_READ;
            state_in = ST_CMY;
         end
         ST_CMY: begin
            cmd.op   = OP_CB_MUL_Y;
            state_in = ST_CMLP;
         end
         ST_CMLP: begin
            cmd.op   = OP_CB_MUL_LP;
            state_in = ST_CLP;
         end
         ST_CLP: begin
            cmd.op   = OP_CB_LP;
            state_in = ST_CMFB;
         end
         ST_CMFB: begin
            cmd.op   = OP_CB_MUL_FB;
            state_in = ST_CWR;
         end
         ST_CWR: begin
            cmd.op = OP_CB_WRITE;
            if (idx_ff == 2'(NCOMB - 1)) begin
               idx_in   = '0;
               state_in = ST_ARD;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_CRD;
            end
         end
         ST_ARD: begin
            cmd.op   = OP_AP_READ;
            state_in = ST_AMUL;
         end
         ST_AMUL: begin
            cmd.op   = OP_AP_MUL;
            state_in = ST_AWR;
         end
         ST_AWR: begin
            cmd.op = OP_AP_WRITE;
            if (idx_ff == 2'(NAP - 1)) begin
               idx_in   = '0;
               state_in = ST_DRY;
            end else begin
               idx_in   = idx_ff + 2'd1;
               state_in = ST_ARD;
            end
         end
         ST_DRY: begin
            cmd.op   = OP_MIX_DRY;
            state_in = ST_WET;
         end
         ST_WET: begin
            cmd.op   = OP_MIX_WET;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold the finished mix until the output register drains
            if (!status.out_full) begin
               cmd.op   = OP_OUT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `SRV_ASSERT_IMP(a_no_accept_in_clear, clock, reset, status.clear_busy, !req_ready)
   `SRV_ASSERT_NXT(a_accept_starts_item, clock, reset, req_valid && req_ready, state_ff == ST_PD)
   `SRV_ASSERT_IMP(a_out_needs_room, clock, reset, cmd.op == OP_OUT, !status.out_full)

endmodule

FILE: hw/rtl/srv_datapath.sv
// ----------------------------------------------------------------------------
// Reverb channel datapath
// Delay memories, pointers, shared multiply-accumulate and output register.
// ----------------------------------------------------------------------------
`include "schroeder_reverb_channel_defines.svh"

module srv_datapath #(
   parameter int PREDELAY_DEPTH = 16384,
   parameter int COMB_DEPTH     = 4096,
   parameter int ALLPASS_DEPTH  = 512,
   parameter int SAMPLE_BITS    = 24
) (
   input  logic                          clock,
   input  logic                          reset,
   input  srv_pkg::cfg_type              cfg,
   input  srv_pkg::cmd_type              cmd,
   output srv_pkg::status_type           status,
   input  logic signed [SAMPLE_BITS-1:0] sample_in,
   output logic signed [SAMPLE_BITS-1:0] sample_out,
   output logic                          rsp_valid,
   input  logic                          rsp_ready
);
   import srv_pkg::*;

   localparam int ACC_W = 51;
   localparam int PD_PW = (PREDELAY_DEPTH > 1) ? $clog2(PREDELAY_DEPTH) : 1;
   localparam int PD_LW = $clog2(PREDELAY_DEPTH + 1);
   localparam int CB_PW = $clog2(COMB_DEPTH);
   localparam int CB_LW = $clog2(COMB_DEPTH + 1);
   localparam int CB_AW = $clog2(NCOMB * COMB_DEPTH);
   localparam int AP_PW = $clog2(ALLPASS_DEPTH);
   localparam int AP_LW = $clog2(ALLPASS_DEPTH + 1);
   localparam int AP_AW = $clog2(NAP * ALLPASS_DEPTH);
   localparam int CLR_A = (PREDELAY_DEPTH > NCOMB * COMB_DEPTH) ?
                          PREDELAY_DEPTH : NCOMB * COMB_DEPTH;
   localparam int CLEAR_LEN = (CLR_A > NAP * ALLPASS_DEPTH) ? CLR_A : NAP * ALLPASS_DEPTH;
   localparam int CLR_W = $clog2(CLEAR_LEN + 1);
   localparam logic [14:0] DAMP_MAX = 15'd32113;
   localparam logic [14:0] FB_MAX   = 15'd32604;
   localparam logic [15:0] AP_GAIN0 = 16'd22938;
   localparam logic [15:0] AP_GAIN1 = 16'd21299;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = ACC_W'(2147483647);
      lo = -hi - ACC_W'(1);
      if (v > hi) return 32'sh7fffffff;
      if (v < lo) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic logic signed [ACC_W-1:0] rnd15(input logic signed [ACC_W-1:0] v);
      return (v + ACC_W'(16384)) >>> 15;
   endfunction

   // memories
   logic signed [SAMPLE_BITS-1:0] pd_mem [PREDELAY_DEPTH];
   logic signed [31:0]            cb_mem [NCOMB * COMB_DEPTH];
   logic signed [31:0]            ap_mem [NAP * ALLPASS_DEPTH];

   logic signed [SAMPLE_BITS-1:0] pd_rd_ff, x_ff, delayed_ff;
   logic signed [31:0]            cb_rd_ff, ap_rd_ff, w_ff;
   logic signed [31:0]            lp_ff [NCOMB];
   logic signed [33:0]            sum_ff;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic [PD_PW-1:0]              pd_ptr_ff;
   logic [CB_PW-1:0]              cb_ptr_ff [NCOMB];
   logic [AP_PW-1:0]              ap_ptr_ff [NAP];
   logic [CLR_W-1:0]              clr_ff;
   logic                          clr_busy_ff;
   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_ff;

   logic [14:0]             d_sat, fb_raw, fb_sat;
   logic [11:0]             cb_len_raw;
   logic [8:0]              ap_len_raw;
   logic [PD_LW-1:0]        pd_len;
   logic [CB_LW-1:0]        cb_len;
   logic [AP_LW-1:0]        ap_len;
   logic [PD_LW:0]          pd_nxt;
   logic [CB_LW:0]          cb_nxt;
   logic [AP_LW:0]          ap_nxt;
   logic [PD_PW-1:0]        pd_adv;
   logic [CB_PW-1:0]        cb_adv;
   logic [AP_PW-1:0]        ap_adv;
   logic [CB_AW-1:0]        cb_addr;
   logic [AP_AW-1:0]        ap_addr;
   logic                    ap_sel;
   logic signed [32:0]      mul_a;
   logic signed [16:0]      mul_b;
   logic signed [49:0]      prod;
   logic signed [ACC_W-1:0] mix_rnd;
   logic signed [ACC_W-1:0] out_hi, out_lo;
   logic signed [SAMPLE_BITS-1:0] mix_sat;

   assign ap_sel     = cmd.idx[0];
   assign d_sat      = (cfg.damping > DAMP_MAX) ? DAMP_MAX : cfg.damping;
   assign fb_raw     = cfg.comb_feedbacks[15 * cmd.idx +: 15];
   assign fb_sat     = (fb_raw > FB_MAX) ? FB_MAX : fb_raw;
   assign cb_len_raw = cfg.comb_lengths[12 * cmd.idx +: 12];
   assign ap_len_raw = cfg.allpass_lengths[9 * ap_sel +: 9];

   // zero length acts as one, lengths beyond the line saturate to its depth
   always_comb begin
      if (cfg.pd_length == '0)
         pd_len = PD_LW'(1);
      else if (32'(cfg.pd_length) > 32'(PREDELAY_DEPTH))
         pd_len = PD_LW'(PREDELAY_DEPTH);
      else
         pd_len = PD_LW'(cfg.pd_length);
      if (cb_len_raw == '0)
         cb_len = CB_LW'(1);
      else if (32'(cb_len_raw) > 32'(COMB_DEPTH))
         cb_len = CB_LW'(COMB_DEPTH);
      else
         cb_len = CB_LW'(cb_len_raw);
      if (ap_len_raw == '0)
         ap_len = AP_LW'(1);
      else if (32'(ap_len_raw) > 32'(ALLPASS_DEPTH))
         ap_len = AP_LW'(ALLPASS_DEPTH);
      else
         ap_len = AP_LW'(ap_len_raw);
   end

   // pointer past a shrunk length still wraps to zero on its next access
   assign pd_nxt = (PD_LW + 1)'(pd_ptr_ff) + 1'b1;
   assign cb_nxt = (CB_LW + 1)'(cb_ptr_ff[cmd.idx]) + 1'b1;
   assign ap_nxt = (AP_LW + 1)'(ap_ptr_ff[ap_sel]) + 1'b1;
   assign pd_adv = (pd_nxt >= (PD_LW + 1)'(pd_len)) ? '0 : pd_nxt[PD_PW-1:0];
   assign cb_adv = (cb_nxt >= (CB_LW + 1)'(cb_len)) ? '0 : cb_nxt[CB_PW-1:0];
   assign ap_adv = (ap_nxt >= (AP_LW + 1)'(ap_len)) ? '0 : ap_nxt[AP_PW-1:0];

   assign cb_addr = CB_AW'(CB_AW'(cmd.idx) * CB_AW'(COMB_DEPTH)) + CB_AW'(cb_ptr_ff[cmd.idx]);
   assign ap_addr = AP_AW'(AP_AW'(ap_sel) * AP_AW'(ALLPASS_DEPTH)) + AP_AW'(ap_ptr_ff[ap_sel]);

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_CB_MUL_Y: begin
            mul_a = 33'(cb_rd_ff);
            mul_b = $signed({1'b0, 16'(16'd32768 - 16'(d_sat))});
         end
         OP_CB_MUL_LP: begin
            mul_a = 33'(lp_ff[cmd.idx]);
            mul_b = $signed({2'b00, d_sat});
         end
         OP_CB_MUL_FB: begin
            mul_a = 33'(lp_ff[cmd.idx]);
            mul_b = $signed({2'b00, fb_sat});
         end
         OP_AP_MUL: begin
            mul_a = 33'(ap_rd_ff);
            mul_b = $signed({1'b0, ap_sel ? AP_GAIN1 : AP_GAIN0});
         end
         OP_MIX_DRY: begin
            mul_a = 33'(x_ff);
            mul_b = $signed({1'b0, cfg.dry_gain});
         end
         OP_MIX_WET: begin
            mul_a = 33'(w_ff);
            mul_b = $signed({1'b0, cfg.wet_gain});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   always_comb begin
      // hold the finished mix while the output step waits
      if (cmd.op == OP_NOP)
         acc_in = acc_ff;
      else if (cmd.op == OP_CB_MUL_LP || cmd.op == OP_MIX_WET)
         acc_in = acc_ff + prod;
      else
         acc_in = ACC_W'(prod);
   end

   assign mix_rnd = (acc_ff + ACC_W'(8192)) >>> 14;
   assign out_hi  = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   assign out_lo  = -out_hi - ACC_W'(1);
   assign mix_sat = (mix_rnd > out_hi) ? out_hi[SAMPLE_BITS-1:0] :
                    (mix_rnd < out_lo) ? out_lo[SAMPLE_BITS-1:0] :
                    mix_rnd[SAMPLE_BITS-1:0];

   // predelay memory
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         if (32'(clr_ff) < 32'(PREDELAY_DEPTH))
            pd_mem[clr_ff[PD_PW-1:0]] <= '0;
      end else if (cmd.op == OP_PD_WRITE) begin
         pd_mem[pd_ptr_ff] <= x_ff;
      end
      if (cmd.op == OP_PD_READ)
         pd_rd_ff <= pd_mem[pd_ptr_ff];
   end

   // comb memory
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         if (32'(clr_ff) < 32'(NCOMB * COMB_DEPTH))
            cb_mem[clr_ff[CB_AW-1:0]] <= '0;
      end else if (cmd.op == OP_CB_WRITE) begin
         cb_mem[cb_addr] <= sat32(ACC_W'(delayed_ff) + rnd15(acc_ff));
      end
      if (cmd.op == OP_CB_READ)
         cb_rd_ff <= cb_mem[cb_addr];
   end

   // allpass memory
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         if (32'(clr_ff) < 32'(NAP * ALLPASS_DEPTH))
            ap_mem[clr_ff[AP_AW-1:0]] <= '0;
      end else if (cmd.op == OP_AP_WRITE) begin
         ap_mem[ap_addr] <= sat32(ACC_W'(w_ff) + rnd15(acc_ff));
      end
      if (cmd.op == OP_AP_READ)
         ap_rd_ff <= ap_mem[ap_addr];
   end

   // payload registers
   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      case (cmd.op)
         OP_PD_READ:  x_ff <= sample_in;
         OP_PD_WRITE: begin
            delayed_ff <= pd_rd_ff;
            sum_ff     <= '0;
         end
         OP_CB_MUL_Y: sum_ff <= sum_ff + 34'(cb_rd_ff);
         OP_AP_READ: begin
            if (cmd.idx == '0)
               w_ff <= sum_ff[33:2];
         end
         OP_AP_WRITE: w_ff <= sat32(ACC_W'(ap_rd_ff) - ACC_W'(w_ff));
         OP_OUT:      out_ff <= mix_sat;
         default: begin
         end
      endcase
   end

   // lowpass state of each comb
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NCOMB; i++)
            lp_ff[i] <= '0;
      end else if (cmd.op == OP_CB_LP) begin
         lp_ff[cmd.idx] <= sat32(rnd15(acc_ff));
      end
   end

   // control state: pointers, clearing pass, output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         pd_ptr_ff    <= '0;
         for (int i = 0; i < NCOMB; i++)
            cb_ptr_ff[i] <= '0;
         for (int i = 0; i < NAP; i++)
            ap_ptr_ff[i] <= '0;
         clr_ff       <= '0;
         clr_busy_ff  <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         if (clr_busy_ff) begin
            clr_ff <= clr_ff + 1'b1;
            if (32'(clr_ff) == 32'(CLEAR_LEN - 1))
               clr_busy_ff <= 1'b0;
         end
         if (cmd.op == OP_PD_WRITE)
            pd_ptr_ff <= pd_adv;
         if (cmd.op == OP_CB_WRITE)
            cb_ptr_ff[cmd.idx] <= cb_adv;
         if (cmd.op == OP_AP_WRITE)
            ap_ptr_ff[ap_sel] <= ap_adv;
         if (cmd.op == OP_OUT)
            out_valid_ff <= 1'b1;
         else if (rsp_ready)
            out_valid_ff <= 1'b0;
      end
   end

   assign status.clear_busy = clr_busy_ff;
   assign status.out_full   = out_valid_ff;
   assign rsp_valid         = out_valid_ff;
   assign sample_out        = out_ff;

   `SRV_ASSERT_IMP(a_no_work_in_clear, clock, reset, clr_busy_ff, cmd.op == OP_NOP)
   `SRV_ASSERT_IMP(a_pd_ptr_in_line, clock, reset, 1'b1, 32'(pd_ptr_ff) < 32'(PREDELAY_DEPTH))
   `SRV_ASSERT_NXT(a_out_loads_valid, clock, reset, cmd.op == OP_OUT, out_valid_ff)

endmodule

FILE: hw/rtl/schroeder_reverb_channel.sv
// ----------------------------------------------------------------------------
// Schroeder reverb channel
// One audio channel: predelay, four damped combs, two allpasses, dry/wet mix.
//
//   channel   direction  payload              handshake
//   req_chan  in         sample_in  (signed)  valid/ready
//   rsp_chan  out        sample_out (signed)  valid/ready
//   csr_*     in/out     64-bit registers     APB-style, pready tied high
//
// Each sample reaches the output register after the sequencer has stepped it
// through every comb and allpass with one shared multiplier and single-port
// delay memories (six steps per comb, three per allpass). A new sample is taken
// only in the idle state, once the previous one has left the output step;
// if the previous result still waits in the output register, the sequencer
// holds in its output step until that transaction drains.
// After reset a clearing pass zeroes the delay memories up to the largest of
// PREDELAY_DEPTH, 4*COMB_DEPTH and 2*ALLPASS_DEPTH entries (16384 by default);
// no sample is accepted during it, register writes are taken as usual.
// ----------------------------------------------------------------------------
module schroeder_reverb_channel #(
   parameter int PREDELAY_DEPTH = 16384,
   parameter int COMB_DEPTH     = 4096,
   parameter int ALLPASS_DEPTH  = 512,
   parameter int SAMPLE_BITS    = 24
) (
   input  logic                        clock,
   input  logic                        reset,
   srv_req_if.sink                     req_chan,
   srv_rsp_if.source                   rsp_chan,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [srv_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [srv_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [srv_pkg::DATA_W-1:0]  csr_prdata,
   output logic                        csr_pready
);
   import srv_pkg::*;

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;
   logic signed [SAMPLE_BITS-1:0] sample_out;

   srv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   srv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   srv_datapath #(
      .PREDELAY_DEPTH (PREDELAY_DEPTH),
      .COMB_DEPTH     (COMB_DEPTH),
      .ALLPASS_DEPTH  (ALLPASS_DEPTH),
      .SAMPLE_BITS    (SAMPLE_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .status     (status),
      .sample_in  (req_chan.sample_in),
      .sample_out (sample_out),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_chan.ready)
   );

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid;
   assign rsp_chan.sample_out = sample_out;

endmodule
